// ===== rtl/orthonormal_axes_from_vector_core_defines.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ORTHONORMAL_AXES_FROM_VECTOR_CORE_DEFINES_SVH
`define ORTHONORMAL_AXES_FROM_VECTOR_CORE_DEFINES_SVH

// Same-cycle implication, held off while reset is high.
`define OAVC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off while reset is high.
`define OAVC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/oavc_pkg.sv =====
`default_nettype none
package oavc_pkg;
  localparam int CW_DEF = 16;
  localparam int FB_DEF = 14;
  localparam int OUTW   = 16;
  // Width of a component magnitude after the normalising shift.
  localparam int MAGW   = 31;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

  // Payload carried alongside the square root and divider stages.
  typedef struct packed {
    logic [5:0][MAGW-1:0] m;
    logic [5:0]           sgn;
    logic                 neg;
    logic [1:0]           status;
  } pay_t;
endpackage
`default_nettype wire

// ===== rtl/orthonormal_axes_from_vector_core.sv =====
// Channel   Dir  Payload                                    Handshake
// s_*       in   tdata: x, y, z (COMPONENT_WIDTH each)      tvalid / tready
// m_*       out  tdata: u_x u_y u_z v_x v_y v_z; tuser: st  tvalid / tready
// cfg_*     in   near_zero_limit (15 bits)                  cfg_we only
//
// One request is taken per cycle while the pipe advances. The seven front stages
// (input, products, direction vectors, shift count, shift, squares, sums) are followed
// by 32 square root stages, one divider set-up and FRACTION_BITS + 1 divider stages,
// then the output register. Reset clears the valid bits and the limit register.
// All stages advance together whenever the output register is empty or being
// taken, so a stall holds every request in place and nothing is lost or repeated.
`default_nettype none
module orthonormal_axes_from_vector_core
  import oavc_pkg::*;
#(
  parameter int COMPONENT_WIDTH = CW_DEF,
  parameter int FRACTION_BITS   = FB_DEF,
  localparam int IW = ((3 * COMPONENT_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [14:0]          cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IW-1:0]        s_tdata,   // x, y, z from bit 0 up, zero padded
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [6*OUTW-1:0]    m_tdata,   // u_x, u_y, u_z, v_x, v_y, v_z from bit 0 up
  output logic [1:0]           m_tuser    // status
);
  localparam int CW   = COMPONENT_WIDTH;
  localparam int FB   = FRACTION_BITS;
  localparam int MW   = 2 * CW;          // magnitude width of a direction component
  localparam int DW3  = 2 * CW + 2;      // signed width of a direction component
  localparam int KMAX = (MW > MAGW) ? MW - MAGW : 0;
  localparam int KW   = (KMAX > 0) ? $clog2(KMAX + 1) : 1;
  localparam int SQW  = 2 * MAGW;
  localparam int NSQ  = 32;              // square root steps, one result bit each
  localparam int DDW  = MAGW + FB + 1;   // dividend width
  localparam int RW   = 33;              // partial remainder width
  localparam int QW   = FB + 1;          // quotient width
  localparam int ND   = FB + 1;          // divider steps
  localparam int PN   = 3 + NSQ + 1 + ND; // payload stages from the shift onward
  localparam int NV   = 4 + PN + 1;      // all valid stages including the output

  logic [14:0] near_zero_limit;
  logic        adv;
  logic [NV-1:0] vl;

  // The whole pipe moves as one; the output register is the only place that waits.
  assign adv      = !vl[NV-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vl[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      near_zero_limit <= '0;
    end else if (cfg_we) begin
      near_zero_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else if (adv) begin
      vl <= {vl[NV-2:0], s_tvalid};
    end
  end

  // Stage 1: register the components and decide which helper vector applies.
  logic signed [CW-1:0] sx, sy, sz;
  logic signed [CW:0]   sye, sze;
  logic [CW:0]          ay, az;
  logic [31:0]          ay32, az32, lim32;
  logic signed [CW-1:0] x1, y1, z1;
  logic                 near1, zero1;

  assign sx    = s_tdata[CW-1:0];
  assign sy    = s_tdata[2*CW-1:CW];
  assign sz    = s_tdata[3*CW-1:2*CW];
  assign sye   = (CW+1)'(sy);
  assign sze   = (CW+1)'(sz);
  assign ay    = (sye < 0) ? $unsigned(-sye) : $unsigned(sye);
  assign az    = (sze < 0) ? $unsigned(-sze) : $unsigned(sze);
  assign ay32  = 32'(ay);
  assign az32  = 32'(az);
  assign lim32 = 32'(near_zero_limit);

  always_ff @(posedge clk) begin
    if (adv) begin
      x1    <= sx;
      y1    <= sy;
      z1    <= sz;
      near1 <= (ay32 <= lim32) && (az32 <= lim32);
      zero1 <= (sx == '0) && (sy == '0) && (sz == '0);
    end
  end

  // Stage 2: the six products, each in its own multiplier.
  logic signed [MW-1:0] pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [CW-1:0] x2, y2, z2;
  logic                 near2, zero2;

  always_ff @(posedge clk) begin
    if (adv) begin
      pxx   <= x1 * x1;
      pyy   <= y1 * y1;
      pzz   <= z1 * z1;
      pxy   <= x1 * y1;
      pxz   <= x1 * z1;
      pyz   <= y1 * z1;
      x2    <= x1;
      y2    <= y1;
      z2    <= z1;
      near2 <= near1;
      zero2 <= zero1;
    end
  end

  // Stage 3: direction vectors of both axes, split into magnitude and sign.
  // Lane 0 (indices 0 to 2) is the first axis, lane 1 (3 to 5) the second.
  logic signed [DW3-1:0] d [6];
  logic signed [DW3-1:0] ex, ey, ez, ssum;
  logic                  deg3c, neg3c;
  logic [5:0][MW-1:0]    mg3;
  logic [5:0]            sgn3;
  logic                  neg3;
  logic [1:0]            st3;

  always_comb begin
    ex   = DW3'(x2);
    ey   = DW3'(y2);
    ez   = DW3'(z2);
    ssum = ey + ez;
    if (near2) begin
      d[0]  = -ey;
      d[1]  = ex;
      d[2]  = '0;
      d[3]  = -DW3'(pxz);
      d[4]  = -DW3'(pyz);
      d[5]  = DW3'(pxx) + DW3'(pyy);
      deg3c = (x2 == '0);
      neg3c = x2[CW-1];
    end else begin
      d[0]  = '0;
      d[1]  = ez;
      d[2]  = -ey;
      d[3]  = -(DW3'(pyy) + DW3'(pzz));
      d[4]  = DW3'(pxy);
      d[5]  = DW3'(pxz);
      deg3c = (ssum == '0);
      neg3c = ssum[DW3-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        mg3[i]  <= MW'(d[i][DW3-1] ? -d[i] : d[i]);
        sgn3[i] <= d[i][DW3-1];
      end
      neg3 <= neg3c;
      if (zero2) begin
        st3 <= ST_ZERO;
      end else if (deg3c) begin
        st3 <= ST_DEGEN;
      end else begin
        st3 <= ST_OK;
      end
    end
  end

  // Stage 4: shift count per lane, taken from the OR of the lane's magnitudes,
  // which has the same leading one as their maximum.
  logic [MW-1:0]      orv [2];
  logic [KW-1:0]      kc  [2];
  logic [KW-1:0]      k4  [2];
  logic [5:0][MW-1:0] mg4;
  logic [5:0]         sgn4;
  logic               neg4;
  logic [1:0]         st4;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      orv[l] = mg3[3*l] | mg3[3*l+1] | mg3[3*l+2];
      kc[l]  = '0;
      for (int b = MAGW; b < MW; b++) begin
        if (orv[l][b]) begin
          kc[l] = KW'(b - MAGW + 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k4[0] <= kc[0];
      k4[1] <= kc[1];
      mg4   <= mg3;
      sgn4  <= sgn3;
      neg4  <= neg3;
      st4   <= st3;
    end
  end

  // Payload pipe from the shift stage to the last divider stage.
  pay_t pr [PN];
  pay_t p0c;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      p0c.m[i] = MAGW'(mg4[i] >> k4[i/3]);
    end
    p0c.sgn    = sgn4;
    p0c.neg    = neg4;
    p0c.status = st4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr[0] <= p0c;
    end
  end

  for (genvar s = 1; s < PN; s++) begin : g_pay
    always_ff @(posedge clk) begin
      if (adv) begin
        pr[s] <= pr[s-1];
      end
    end
  end

  // Squares, then the sum of squares per lane.
  logic [5:0][SQW-1:0] sq;
  logic [63:0]         rs [2][NSQ+1];
  logic [63:0]         rr [2][NSQ+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        sq[i] <= pr[0].m[i] * pr[0].m[i];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_sum
    always_ff @(posedge clk) begin
      if (adv) begin
        rs[l][0] <= 64'(sq[3*l]) + 64'(sq[3*l+1]) + 64'(sq[3*l+2]);
        rr[l][0] <= '0;
      end
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar j = 1; j <= NSQ; j++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'(1) << (62 - 2 * (j - 1));
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [63:0] t;
      assign t = rr[l][j-1] + BITV;
      always_ff @(posedge clk) begin
        if (adv) begin
          if (rs[l][j-1] >= t) begin
            rs[l][j] <= rs[l][j-1] - t;
            rr[l][j] <= (rr[l][j-1] >> 1) + BITV;
          end else begin
            rs[l][j] <= rs[l][j-1];
            rr[l][j] <= rr[l][j-1] >> 1;
          end
        end
      end
    end
  end

  // Divider set-up: rounded dividend and the starting remainder.
  logic [31:0]    dn [2][ND+1];
  logic [DDW-1:0] dd [6][ND+1];
  logic [RW-1:0]  dr [6][ND+1];
  logic [QW-1:0]  dq [6][ND+1];
  logic [31:0]    nn [2];
  logic [DDW-1:0] dc [6];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nn[l] = (rr[l][NSQ][31:0] == '0) ? 32'd1 : rr[l][NSQ][31:0];
    end
    for (int i = 0; i < 6; i++) begin
      dc[i] = (DDW'(pr[3+NSQ-1].m[i]) << FB) + DDW'(nn[i/3] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn[0][0] <= nn[0];
      dn[1][0] <= nn[1];
    end
  end

  for (genvar i = 0; i < 6; i++) begin : g_dset
    always_ff @(posedge clk) begin
      if (adv) begin
        dd[i][0] <= dc[i];
        dr[i][0] <= RW'(dc[i] >> (FB + 1));
        dq[i][0] <= '0;
      end
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 1; j <= ND; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        dn[0][j] <= dn[0][j-1];
        dn[1][j] <= dn[1][j-1];
      end
    end
    for (genvar i = 0; i < 6; i++) begin : g_comp
      logic [RW-1:0] t;
      assign t = {dr[i][j-1][RW-2:0], dd[i][j-1][ND-j]};
      always_ff @(posedge clk) begin
        if (adv) begin
          dd[i][j] <= dd[i][j-1];
          if (t >= RW'(dn[i/3][j-1])) begin
            dr[i][j] <= t - RW'(dn[i/3][j-1]);
            dq[i][j] <= {dq[i][j-1][QW-2:0], 1'b1};
          end else begin
            dr[i][j] <= t;
            dq[i][j] <= {dq[i][j-1][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Output register: apply signs, or clear the axes when the status is not ok.
  logic [5:0][OUTW-1:0] oq;
  logic [1:0]           ost;
  logic [OUTW-1:0]      qo [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      qo[i] = OUTW'(dq[i][ND]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        if (pr[PN-1].status != ST_OK) begin
          oq[i] <= '0;
        end else if (pr[PN-1].sgn[i] ^ pr[PN-1].neg) begin
          oq[i] <= -qo[i];
        end else begin
          oq[i] <= qo[i];
        end
      end
      ost <= pr[PN-1].status;
    end
  end

  assign m_tdata = oq;
  assign m_tuser = ost;
endmodule
`default_nettype wire

// ===== rtl/oavc_checker.sv =====
`default_nettype none
`include "orthonormal_axes_from_vector_core_defines.svh"
module oavc_checker
  import oavc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [6*OUTW-1:0] m_tdata,
  input logic [1:0]        m_tuser
);
  // A stalled result holds its value.
  `OAVC_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // A request with a failure status carries cleared axes.
  `OAVC_ASSERT_IMPLY(a_clear, clk, rst, m_tvalid && (m_tuser != ST_OK), m_tdata == '0)
  // An empty output register never holds back the input.
  `OAVC_ASSERT_IMPLY(a_ready, clk, rst, !m_tvalid, s_tready)
  // A stalled output stalls the whole pipe.
  `OAVC_ASSERT_IMPLY(a_stall, clk, rst, m_tvalid && !m_tready, !s_tready)
  // Status is one of the three defined codes.
  `OAVC_ASSERT_IMPLY(a_code, clk, rst, m_tvalid, (m_tuser == ST_OK) || (m_tuser == ST_ZERO) || (m_tuser == ST_DEGEN))
endmodule

bind orthonormal_axes_from_vector_core oavc_checker u_oavc_checker (.*);
`default_nettype wire
